FILE: sv/pid_controller_clamped_macros.svh
// ----------------------------------------------------------------------------
// pid_controller_clamped assertion macros
// Concurrent check helpers; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

`ifndef SYNTHESIS

// condition in the same cycle
`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pid_controller_clamped check failed");

// condition in the following cycle
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pid_controller_clamped check failed");

`else

`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared register indexes, item kinds and pipeline control type.
// ----------------------------------------------------------------------------
package pidc_pkg;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_KP_GAIN    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KI_GAIN    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KD_GAIN    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_P_ON_ERROR = 3'd5;

	// item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// control that rides along with a pipeline stage
	typedef struct packed {
		logic valid;
		logic clear;
	} pidc_ctl_t;

endpackage

FILE: sv/pidc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pidc_cfg_regs
// Gain, clamp and mode registers behind the plain write port.
// ----------------------------------------------------------------------------
module pidc_cfg_regs #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pidc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [DATA_WIDTH-1:0]                 cfg_data,
	output logic signed [DATA_WIDTH-1:0]          kp_gain,
	output logic signed [DATA_WIDTH-1:0]          ki_gain,
	output logic signed [DATA_WIDTH-1:0]          kd_gain,
	output logic signed [DATA_WIDTH-1:0]          out_min,
	output logic signed [DATA_WIDTH-1:0]          out_max,
	output logic                                  p_on_error
);
	import pidc_pkg::*;

	logic signed [DATA_WIDTH-1:0] kp_q, ki_q, kd_q, min_q, max_q;
	logic                         pon_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= '0;
			ki_q  <= '0;
			kd_q  <= '0;
			min_q <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
			max_q <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
			pon_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP_GAIN:    kp_q  <= cfg_data;
				REG_KI_GAIN:    ki_q  <= cfg_data;
				REG_KD_GAIN:    kd_q  <= cfg_data;
				REG_OUT_MIN:    min_q <= cfg_data;
				REG_OUT_MAX:    max_q <= cfg_data;
				REG_P_ON_ERROR: pon_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign kp_gain    = kp_q;
	assign ki_gain    = ki_q;
	assign kd_gain    = kd_q;
	assign out_min    = min_q;
	assign out_max    = max_q;
	assign p_on_error = pon_q;

endmodule

FILE: sv/pidc_mul_stage.sv
// ----------------------------------------------------------------------------
// pidc_mul_stage
// Input register, error and measurement change, three gain products floored.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_macros.svh"

module pidc_mul_stage #(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8,
	localparam int PROD_W        = 2*DATA_WIDTH + 1 - GAIN_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input beat
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_kind,
	input  logic signed [DATA_WIDTH-1:0]        in_target,
	input  logic signed [DATA_WIDTH-1:0]        in_measured,
	// gains
	input  logic signed [DATA_WIDTH-1:0]        kp_gain,
	input  logic signed [DATA_WIDTH-1:0]        ki_gain,
	input  logic signed [DATA_WIDTH-1:0]        kd_gain,
	// product stage towards the sum stage
	input  logic                                take,
	output pidc_pkg::pidc_ctl_t                 ctl_s2,
	output logic signed [PROD_W-1:0]            kp_term_s2,
	output logic signed [PROD_W-1:0]            ki_term_s2,
	output logic signed [PROD_W-1:0]            kd_term_s2
);
	import pidc_pkg::*;

	localparam int DIFF_W = DATA_WIDTH + 1;
	localparam int FULL_W = 2*DATA_WIDTH + 1;

	pidc_ctl_t                    ctl_s1;
	logic signed [DATA_WIDTH-1:0] target_s1, meas_s1;
	logic signed [DATA_WIDTH-1:0] last_q;
	pidc_ctl_t                    ctl2_q;
	logic signed [PROD_W-1:0]     kp2_q, ki2_q, kd2_q;

	logic                         load_s2, load_s1;
	logic signed [DIFF_W-1:0]     err, dmeas;
	logic signed [FULL_W-1:0]     kp_full, ki_full, kd_full;

	// stage enables
	assign load_s2  = !ctl2_q.valid || take;
	assign load_s1  = !ctl_s1.valid || load_s2;
	assign in_ready = load_s1;

	// differences and full products
	always_comb begin
		err     = DIFF_W'(target_s1) - DIFF_W'(meas_s1);
		dmeas   = DIFF_W'(meas_s1) - DIFF_W'(last_q);
		kp_full = FULL_W'(err) * FULL_W'(kp_gain);
		ki_full = FULL_W'(err) * FULL_W'(ki_gain);
		kd_full = FULL_W'(dmeas) * FULL_W'(kd_gain);
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (load_s1) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.clear <= in_kind == KIND_CLEAR;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			target_s1 <= in_target;
			meas_s1   <= in_measured;
		end
	end

	// previous measurement, follows items as they leave the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (ctl_s1.valid && load_s2) begin
			last_q <= ctl_s1.clear ? '0 : meas_s1;
		end
	end

	// product register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl2_q <= '0;
		end else if (load_s2) begin
			ctl2_q <= ctl_s1;
		end
	end

	// product register payload, floor by dropping fraction bits
	always_ff @(posedge clk) begin
		if (load_s2 && ctl_s1.valid) begin
			kp2_q <= kp_full[FULL_W-1:GAIN_FRAC_BITS];
			ki2_q <= ki_full[FULL_W-1:GAIN_FRAC_BITS];
			kd2_q <= kd_full[FULL_W-1:GAIN_FRAC_BITS];
		end
	end

	assign ctl_s2     = ctl2_q;
	assign kp_term_s2 = kp2_q;
	assign ki_term_s2 = ki2_q;
	assign kd_term_s2 = kd2_q;

	// checks
	`PIDC_ASSERT_SAME(a_stall_means_full, clk, arst_n, !in_ready, ctl_s1.valid && ctl2_q.valid)
	`PIDC_ASSERT_NEXT(a_clear_zeroes_last, clk, arst_n, ctl_s1.valid && ctl_s1.clear && load_s2, last_q == '0)
	`PIDC_ASSERT_NEXT(a_sample_keeps_meas, clk, arst_n, ctl_s1.valid && !ctl_s1.clear && load_s2, last_q == $past(meas_s1))

endmodule

FILE: sv/pidc_sum_stage.sv
// ----------------------------------------------------------------------------
// pidc_sum_stage
// Integrator update with clamp, drive sum with clamp, output register.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_macros.svh"

module pidc_sum_stage #(
	parameter int DATA_WIDTH = 16,
	parameter int PROD_W     = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// product stage
	input  pidc_pkg::pidc_ctl_t                 ctl_s2,
	input  logic signed [PROD_W-1:0]            kp_term_s2,
	input  logic signed [PROD_W-1:0]            ki_term_s2,
	input  logic signed [PROD_W-1:0]            kd_term_s2,
	output logic                                take,
	// configuration
	input  logic                                p_on_error,
	input  logic signed [DATA_WIDTH-1:0]        out_min,
	input  logic signed [DATA_WIDTH-1:0]        out_max,
	// result beat
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [DATA_WIDTH-1:0]        drive
);
	import pidc_pkg::*;

	localparam int SUM_W = ((PROD_W > DATA_WIDTH) ? PROD_W : DATA_WIDTH) + 2;

	logic signed [DATA_WIDTH-1:0] integ_q;
	logic                         valid_s3;
	logic signed [DATA_WIDTH-1:0] drive_s3;

	logic                         adv;
	logic signed [SUM_W-1:0]      lo_x, hi_x, isum, dsum, p_x;
	logic signed [DATA_WIDTH-1:0] integ_next, drive_next;

	// upper limit first, then lower
	function automatic logic signed [DATA_WIDTH-1:0] clamp_val(
		input logic signed [SUM_W-1:0]      v,
		input logic signed [SUM_W-1:0]      lo,
		input logic signed [SUM_W-1:0]      hi
	);
		logic signed [DATA_WIDTH-1:0] r;
		if (v > hi)
			r = hi[DATA_WIDTH-1:0];
		else if (v < lo)
			r = lo[DATA_WIDTH-1:0];
		else
			r = v[DATA_WIDTH-1:0];
		return r;
	endfunction

	assign take = !valid_s3 || out_ready;
	assign adv  = ctl_s2.valid && take;

	// integrator and drive arithmetic
	always_comb begin
		lo_x       = SUM_W'(out_min);
		hi_x       = SUM_W'(out_max);
		isum       = SUM_W'(integ_q) + SUM_W'(ki_term_s2);
		integ_next = clamp_val(isum, lo_x, hi_x);
		p_x        = p_on_error ? SUM_W'(kp_term_s2) : '0;
		dsum       = p_x + SUM_W'(integ_next) - SUM_W'(kd_term_s2);
		drive_next = clamp_val(dsum, lo_x, hi_x);
	end

	// integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (adv) begin
			integ_q <= ctl_s2.clear ? '0 : integ_next;
		end
	end

	// output register control, clear items give no beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take) begin
			valid_s3 <= ctl_s2.valid && !ctl_s2.clear;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv && !ctl_s2.clear) begin
			drive_s3 <= drive_next;
		end
	end

	assign out_valid = valid_s3;
	assign drive     = drive_s3;

	// checks
	`PIDC_ASSERT_NEXT(a_clear_zeroes_integ, clk, arst_n, adv && ctl_s2.clear, integ_q == '0)
	`PIDC_ASSERT_NEXT(a_clear_no_beat, clk, arst_n, adv && ctl_s2.clear, !valid_s3)

endmodule

FILE: sv/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped
// PID controller, derivative on measurement, clamped integrator and drive.
// ----------------------------------------------------------------------------
// One sample beat is taken every clock cycle unless the drive stream stalls;
// it passes the input register, gain product register and output register.
// The rate is set by the integrator loop, which adds, clamps and feeds the
// drive sum combinationally in the sum stage. A clear beat (tuser high) zeroes
// the integrator and last measurement and gives no output beat. Configuration
// is to be written through cfg_we/cfg_index/cfg_data only while no beat is in
// flight; the block does not enforce this. Gains are signed with GAIN_FRAC_BITS
// fraction bits; products are floored. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module pid_controller_clamped #(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8,
	localparam int IN_TDATA_W    = ((2*DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [pidc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [DATA_WIDTH-1:0]             cfg_data,
	// sample stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [IN_TDATA_W-1:0]             s_axis_tdata,   // target, measured, zero pad
	input  logic                              s_axis_tuser,   // kind
	// drive stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [OUT_TDATA_W-1:0]            m_axis_tdata    // drive, zero pad
);
	import pidc_pkg::*;

	localparam int PROD_W = 2*DATA_WIDTH + 1 - GAIN_FRAC_BITS;

	logic signed [DATA_WIDTH-1:0] kp_gain, ki_gain, kd_gain, out_min, out_max;
	logic                         p_on_error;
	logic                         take;
	pidc_ctl_t                    ctl_s2;
	logic signed [PROD_W-1:0]     kp_term_s2, ki_term_s2, kd_term_s2;
	logic signed [DATA_WIDTH-1:0] drive;
	logic [DATA_WIDTH-1:0]        drive_bits;

	// configuration registers
	pidc_cfg_regs #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.kp_gain    (kp_gain),
		.ki_gain    (ki_gain),
		.kd_gain    (kd_gain),
		.out_min    (out_min),
		.out_max    (out_max),
		.p_on_error (p_on_error)
	);

	// input register and gain products
	pidc_mul_stage #(
		.DATA_WIDTH     (DATA_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mul (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_kind     (s_axis_tuser),
		.in_target   (s_axis_tdata[DATA_WIDTH-1:0]),
		.in_measured (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.kp_gain     (kp_gain),
		.ki_gain     (ki_gain),
		.kd_gain     (kd_gain),
		.take        (take),
		.ctl_s2      (ctl_s2),
		.kp_term_s2  (kp_term_s2),
		.ki_term_s2  (ki_term_s2),
		.kd_term_s2  (kd_term_s2)
	);

	// integrator, drive sum and output register
	pidc_sum_stage #(
		.DATA_WIDTH (DATA_WIDTH),
		.PROD_W     (PROD_W)
	) u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s2     (ctl_s2),
		.kp_term_s2 (kp_term_s2),
		.ki_term_s2 (ki_term_s2),
		.kd_term_s2 (kd_term_s2),
		.take       (take),
		.p_on_error (p_on_error),
		.out_min    (out_min),
		.out_max    (out_max),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.drive      (drive)
	);

	// zero-padded output data
	assign drive_bits   = drive;
	assign m_axis_tdata = OUT_TDATA_W'(drive_bits);

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Sends setpoint/measurement beats and clear beats through the controller
// under several gain and limit settings, with bursty input and a stalling
// output. Every drive beat is checked against a local model of the
// integrator and the last measurement, or against the plan's given drive.
// ----------------------------------------------------------------------------
module testbench;
	import pidc_pkg::*;

	localparam int W             = 16;
	localparam int FRAC          = 8;
	localparam int IN_W          = 32;
	localparam int OUT_W         = 16;
	localparam int LATENCY       = 3;
	localparam int SETTLE        = LATENCY + 4;
	localparam int PHASES        = 8;
	localparam int PHASE_SAMPLES = 48;
	localparam int REPORT_MAX    = 10;

	typedef logic signed [W-1:0] word_t;

	// one line of the directed plan: a register write or a beat
	typedef struct packed {
		logic                   is_cfg;
		logic [CFG_INDEX_W-1:0] index;
		logic [W-1:0]           value;
		logic                   kind;
		logic [W-1:0]           target;
		logic [W-1:0]           measured;
		logic                   known;
		logic [W-1:0]           drive;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [W-1:0]           cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_W-1:0]        s_axis_tdata;   // target, measured
	logic                   s_axis_tuser;   // kind
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_W-1:0]       m_axis_tdata;   // drive

	// model copy of registers and state
	word_t  kp_gain, ki_gain, kd_gain, out_min, out_max;
	logic   p_on_error;
	longint integ_acc;
	longint prev_meas;

	word_t  pending_drive[$];
	int     mismatches;
	int     burst_left;
	int     burst_max;
	logic   row_known;
	word_t  row_drive;
	row_t   plan[$];

	pid_controller_clamped dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	// upper limit wins, then lower
	function automatic longint clamp_to_limits(longint v);
		if (v > longint'(out_max))
			return longint'(out_max);
		if (v < longint'(out_min))
			return longint'(out_min);
		return v;
	endfunction

	// advance the controller state by one sample and return its drive
	function automatic word_t predict_drive(word_t target, word_t measured);
		longint err;
		longint dmeas;
		longint sum;
		err = longint'(target) - longint'(measured);
		dmeas = longint'(measured) - prev_meas;
		integ_acc = clamp_to_limits(integ_acc + ((longint'(ki_gain) * err) >>> FRAC));
		sum = p_on_error ? ((longint'(kp_gain) * err) >>> FRAC) : 64'sd0;
		sum = sum + integ_acc - ((longint'(kd_gain) * dmeas) >>> FRAC);
		prev_meas = longint'(measured);
		return word_t'(clamp_to_limits(sum));
	endfunction

	task automatic flag_error(string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s", $time, msg);
	endtask

	// watch both streams at the rising edge; results first, then new beats
	always @(posedge clk) begin : monitor
		word_t got;
		word_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[W-1:0];
				if (pending_drive.size() == 0) begin
					flag_error($sformatf("unexpected drive beat %0d", got));
				end else begin
					want = pending_drive.pop_front();
					if (got !== want)
						flag_error($sformatf("drive mismatch: expected %0d, got %0d",
							want, got));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == KIND_CLEAR) begin
					integ_acc = 0;
					prev_meas = 0;
				end else begin
					want = predict_drive(s_axis_tdata[W-1:0], s_axis_tdata[2*W-1:W]);
					if (row_known)
						want = row_drive;
					pending_drive.push_back(want);
				end
			end
		end
	end

	// output stalls: stretches of always ready, mostly ready, mostly stalled, periodic
	always @(negedge clk) begin : sink
		static int mode = 0;
		static int mode_left = 0;
		static int tick = 0;
		if (mode_left == 0) begin
			mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 120);
		end
		mode_left--;
		tick++;
		case (mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((tick % 7) < 3);
		endcase
	end

	// register write at a falling edge, model copy updated alongside
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_KP_GAIN:    kp_gain = val;
			REG_KI_GAIN:    ki_gain = val;
			REG_KD_GAIN:    kd_gain = val;
			REG_OUT_MIN:    out_min = val;
			REG_OUT_MAX:    out_max = val;
			REG_P_ON_ERROR: p_on_error = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// drain every outstanding drive beat, then let a clear beat settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_drive.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// one beat, held until accepted; burst bookkeeping afterwards
	task automatic send_beat(logic kind, word_t target, word_t measured, logic known,
			word_t drive);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {measured, target};
		row_known = known;
		row_drive = drive;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(8, 30)) @(negedge clk);
			else
				repeat ($urandom_range(1, 4)) @(negedge clk);
			burst_left = $urandom_range(0, burst_max);
		end
	endtask

	function automatic row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, word_t val);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.index = idx;
		r.value = val;
		return r;
	endfunction

	function automatic row_t beat_row(logic kind, word_t target, word_t measured,
			logic known, word_t drive);
		row_t r;
		r = '0;
		r.kind = kind;
		r.target = target;
		r.measured = measured;
		r.known = known;
		r.drive = drive;
		return r;
	endfunction

	// mix of full range, extremes and values near zero
	function automatic word_t pick_value();
		case ($urandom_range(0, 4))
			0: return word_t'($urandom);
			1: return word_t'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			default: return word_t'(int'($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	function automatic word_t pick_gain();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3, 4, 5, 6: return word_t'(int'($urandom_range(0, 1024)) - 512);
			default: return word_t'($urandom);
		endcase
	endfunction

	// random settings for one phase of the random part
	task automatic random_config();
		word_t a;
		word_t b;
		write_reg(REG_KP_GAIN, pick_gain());
		write_reg(REG_KI_GAIN, pick_gain());
		write_reg(REG_KD_GAIN, pick_gain());
		case ($urandom_range(0, 5))
			0: begin
				a = 16'sh8000;
				b = 16'sh7fff;
			end
			1: begin
				// crossed limits
				a = word_t'(int'($urandom_range(1, 3000)));
				b = -a;
			end
			2: begin
				a = word_t'($urandom);
				b = word_t'($urandom);
				if (a > b) begin
					a = a ^ b;
					b = a ^ b;
					a = a ^ b;
				end
			end
			default: begin
				a = word_t'(-int'($urandom_range(0, 3000)));
				b = word_t'(int'($urandom_range(0, 3000)));
			end
		endcase
		write_reg(REG_OUT_MIN, a);
		write_reg(REG_OUT_MAX, b);
		// upper bits of the mode register are ignored
		write_reg(REG_P_ON_ERROR, {15'($urandom), 1'($urandom)});
	endtask

	// stimulus
	initial begin : stimulus
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_SAMPLE;
		m_axis_tready = 1'b0;
		row_known = 1'b0;
		row_drive = '0;
		mismatches = 0;
		burst_left = 0;
		burst_max = 8;
		kp_gain = 16'sh0000;
		ki_gain = 16'sh0000;
		kd_gain = 16'sh0000;
		out_min = 16'sh8000;
		out_max = 16'sh7fff;
		p_on_error = 1'b1;
		integ_acc = 0;
		prev_meas = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: all gains zero, so the drive is zero
		plan.push_back(beat_row(KIND_SAMPLE, 0, 0, 1'b1, 0));
		plan.push_back(beat_row(KIND_SAMPLE, 16'sh7fff, 16'sh8000, 1'b1, 0));
		plan.push_back(beat_row(KIND_SAMPLE, 16'sh8000, 16'sh7fff, 1'b1, 0));
		plan.push_back(beat_row(KIND_SAMPLE, -1, -1, 1'b1, 0));
		// unity proportional gain: drive is the error, saturated at full range
		plan.push_back(cfg_row(REG_KP_GAIN, 16'sd256));
		plan.push_back(beat_row(KIND_SAMPLE, 16'sh7fff, 16'sh8000, 1'b1, 16'sh7fff));
		plan.push_back(beat_row(KIND_SAMPLE, 16'sh8000, 16'sh7fff, 1'b1, 16'sh8000));
		plan.push_back(beat_row(KIND_SAMPLE, 100, 40, 1'b1, 60));
		// proportional term switched off
		plan.push_back(cfg_row(REG_P_ON_ERROR, 0));
		plan.push_back(beat_row(KIND_SAMPLE, 100, 40, 1'b1, 0));
		// extreme negative proportional and derivative gains, half integral gain, negative products floored
		plan.push_back(cfg_row(REG_P_ON_ERROR, 1));
		plan.push_back(cfg_row(REG_KI_GAIN, 16'sd128));
		plan.push_back(cfg_row(REG_KD_GAIN, 16'sh8000));
		plan.push_back(cfg_row(REG_KP_GAIN, 16'sh8000));
		plan.push_back(beat_row(KIND_SAMPLE, 1000, 3, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, -5, 7, 1'b0, 0));
		// clear beat: fields ignored, state back to zero, no drive beat
		plan.push_back(beat_row(KIND_CLEAR, -1, 16'sh7fff, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, -5, 7, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, 16'sh8000, 16'sh8000, 1'b0, 0));
		// extreme positive gains, narrow limits on integrator and drive
		plan.push_back(cfg_row(REG_KI_GAIN, 16'sh7fff));
		plan.push_back(cfg_row(REG_KD_GAIN, 16'sh7fff));
		plan.push_back(cfg_row(REG_KP_GAIN, 16'sh7fff));
		plan.push_back(cfg_row(REG_OUT_MIN, -50));
		plan.push_back(cfg_row(REG_OUT_MAX, 50));
		plan.push_back(beat_row(KIND_SAMPLE, 20, -3, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, -20, 30, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, 16'sh7fff, 16'sh8000, 1'b0, 0));
		// crossed limits: above the upper gives upper, else below the lower gives lower
		plan.push_back(cfg_row(REG_OUT_MIN, 100));
		plan.push_back(cfg_row(REG_OUT_MAX, -100));
		plan.push_back(beat_row(KIND_SAMPLE, 0, 0, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, -300, 0, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, 300, -1, 1'b0, 0));
		// full range again, most negative integral gain
		plan.push_back(cfg_row(REG_KI_GAIN, 16'sh8000));
		plan.push_back(cfg_row(REG_OUT_MIN, 16'sh8000));
		plan.push_back(cfg_row(REG_OUT_MAX, 16'sh7fff));
		plan.push_back(beat_row(KIND_SAMPLE, 500, -500, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, -500, 500, 1'b0, 0));
		plan.push_back(beat_row(KIND_CLEAR, 16'sh7fff, 16'sh8000, 1'b0, 0));
		plan.push_back(beat_row(KIND_SAMPLE, 1, 0, 1'b0, 0));

		// directed part
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_idle();
				write_reg(plan[i].index, plan[i].value);
			end else begin
				send_beat(plan[i].kind, plan[i].target, plan[i].measured, plan[i].known,
					plan[i].drive);
			end
		end

		// random part: fresh settings each phase, some phases with very long input bursts
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			random_config();
			burst_max = (ph % 3 == 0) ? 1000 : $urandom_range(2, 16);
			burst_left = $urandom_range(0, burst_max);
			n = 0;
			while (n < PHASE_SAMPLES) begin
				if ($urandom_range(0, 19) == 0) begin
					send_beat(KIND_CLEAR, pick_value(), pick_value(), 1'b0, 0);
				end else begin
					send_beat(KIND_SAMPLE, pick_value(), pick_value(), 1'b0, 0);
					n++;
				end
			end
		end

		// drain and settle
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (pending_drive.size() != 0)
			flag_error($sformatf("%0d drive beats never arrived", pending_drive.size()));

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/pidc_pkg.sv
sv/pidc_cfg_regs.sv
sv/pidc_mul_stage.sv
sv/pidc_sum_stage.sv
sv/pid_controller_clamped.sv
bench/testbench.sv
